### rtl/core/s2lab_pkg.sv
package s2lab_pkg;

  localparam int QB = 20;
  localparam int OUT_FRAC_BITS_DEF = 8;

  localparam int LIN_W = 21;
  localparam int COEF_W = 24;
  localparam int MAT_SH = 24;
  localparam int PROD_W = COEF_W + LIN_W;
  localparam int SUM_W = PROD_W + 2;
  localparam int XYZ_W = 22;
  localparam int F_W = 21;

  localparam int CBRT_STEPS = 21;
  localparam int CBRT_LAT = CBRT_STEPS + 1;
  localparam int RAD_SH = 2 * QB;
  localparam int RAD_W = 3 * CBRT_STEPS;
  localparam int REM_W = 48;
  localparam int SQ_W = 2 * F_W;

  localparam int LN_V_W = 14;
  localparam int LN_N_W = 27;
  localparam int RECIP_SH = 37;
  localparam int LN_P_W = 55;

  localparam int ACC_W = 32;
  localparam int PIPE_DEPTH = CBRT_LAT + 6;

  localparam longint unsigned ONE_Q20 = 64'd1 << QB;
  localparam longint unsigned HALF_Q20 = 64'd1 << (QB - 1);
  localparam longint unsigned V_MAX = 64'd1 << (QB + 1);
  localparam longint unsigned MAT_RND = 64'd1 << (MAT_SH - 1);
  localparam longint unsigned F_THRESH = (64'd8856 << QB) / 64'd1000000;
  localparam longint unsigned F_OFFSET = ((64'd16 << QB) + 64'd58) / 64'd116;
  localparam longint unsigned LIN_SLOPE = 64'd7787;
  localparam longint unsigned LIN_RND = 64'd500;
  localparam longint unsigned RECIP_M = ((64'd1 << RECIP_SH) + 64'd999) / 64'd1000;
  localparam longint unsigned L_MUL = 64'd116;
  localparam longint unsigned A_MUL = 64'd500;
  localparam longint unsigned B_MUL = 64'd200;
  localparam longint unsigned L_OFS = 64'd16 << QB;
  localparam longint unsigned L_MAX = 64'd100 << QB;
  localparam longint unsigned L_SAT = 64'd32767;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] a_star;
    logic signed [15:0] b_star;
  } lab_out_t;

  typedef logic [LIN_W-1:0] lin_tab_t [0:255];
  typedef logic [COEF_W-1:0] mat_t [0:8];

  function automatic logic [COEF_W-1:0] coef_x(input longint unsigned n);
    return COEF_W'((n * 64'd167772160 + 64'd47523) / 64'd95047);
  endfunction

  function automatic logic [COEF_W-1:0] coef_y(input longint unsigned n);
    return COEF_W'((n * 64'd16777216 + 64'd5000) / 64'd10000);
  endfunction

  function automatic logic [COEF_W-1:0] coef_z(input longint unsigned n);
    return COEF_W'((n * 64'd167772160 + 64'd54441) / 64'd108883);
  endfunction

  localparam mat_t MAT = '{
    coef_x(64'd4124), coef_x(64'd3576), coef_x(64'd1805),
    coef_y(64'd2126), coef_y(64'd7152), coef_y(64'd722),
    coef_z(64'd193),  coef_z(64'd1192), coef_z(64'd9505)
  };

  // Gamma removal: t^2.4 is built as t^2 * u with u the largest value whose
  // fifth power stays at or below t^2, all in Q20.
  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    longint unsigned c, t, t2, lo, hi, mid, p2, p4, p5;
    for (int i = 0; i < 256; i++) begin
      c = 64'(i);
      if (c * 64'd100000 <= 64'd4045 * 64'd255) begin
        tab[i] = LIN_W'((c * 64'd100 * ONE_Q20 + 64'd164730) / 64'd329460);
      end else begin
        t = (((64'd1000 * c + 64'd14025) << QB) + 64'd134512) / 64'd269025;
        t2 = (t * t + HALF_Q20) >> QB;
        lo = 64'd0;
        hi = ONE_Q20;
        while (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          p2 = (mid * mid + HALF_Q20) >> QB;
          p4 = (p2 * p2 + HALF_Q20) >> QB;
          p5 = (p4 * mid + HALF_Q20) >> QB;
          if (p5 <= t2) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        tab[i] = LIN_W'((t * t * lo + (64'd1 << 39)) >> 40);
      end
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

### rtl/core/srgb_to_cielab_convert.sv
// Channel  Direction  Handshake            Payload
// in       input      start / busy         in_pixel (pix_in_t: red, green, blue)
// out      output     out_valid, 1 cycle   out_lab (lab_out_t: lightness, a_star, b_star)
//
// A pixel transaction is accepted on every cycle with start high and busy low.
// Each result passes through the input, table and matrix registers, the 21-step
// cube root and its select, and then the scaling registers.
// The synchronous active-low reset clears the valid pipeline; busy is high in reset
// and clears on the clock edge that samples reset released.
// The receiver cannot stall, so the pipeline advances on every clock.
module srgb_to_cielab_convert #(
  parameter int OUT_FRAC_BITS = s2lab_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  s2lab_pkg::pix_in_t  in_pixel,
  output logic                out_valid,
  output s2lab_pkg::lab_out_t out_lab
);
  import s2lab_pkg::*;

  localparam int SH = QB - OUT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (SH - 1);
  localparam logic signed [ACC_W-1:0] L_TOP = ACC_W'(L_MAX);
  localparam logic signed [ACC_W-1:0] L_LIM = ACC_W'(L_SAT);
  localparam logic signed [ACC_W-1:0] SAT_HI = 32767;
  localparam logic signed [ACC_W-1:0] SAT_LO = -32768;

  logic                    busy_r;
  logic [PIPE_DEPTH-1:0]   vld_r;
  pix_in_t                 pix_r;
  logic [LIN_W-1:0]        lin_r  [3];
  logic [PROD_W-1:0]       prod_r [9];
  logic [SUM_W-1:0]        sum_w  [3];
  logic [XYZ_W-1:0]        xyz_r  [3];
  logic [F_W-1:0]          f_w    [3];
  logic signed [ACC_W-1:0] l_r;
  logic signed [ACC_W-1:0] a_r;
  logic signed [ACC_W-1:0] b_r;
  logic signed [ACC_W-1:0] l_clip;
  logic signed [ACC_W-1:0] l_rnd;
  lab_out_t                out_r;

  function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    s = v + RND_HALF - ACC_W'(v[ACC_W-1]);
    s = s >>> SH;
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return 16'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[PIPE_DEPTH-2:0], start & ~busy_r};
    end
  end

  always_ff @(posedge clk) begin
    pix_r    <= in_pixel;
    lin_r[0] <= LIN_TAB[pix_r.red];
    lin_r[1] <= LIN_TAB[pix_r.green];
    lin_r[2] <= LIN_TAB[pix_r.blue];
    for (int i = 0; i < 9; i++) begin
      prod_r[i] <= PROD_W'(MAT[i]) * PROD_W'(lin_r[i % 3]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_w[r] = SUM_W'(prod_r[3*r]) + SUM_W'(prod_r[3*r+1]) + SUM_W'(prod_r[3*r+2])
               + SUM_W'(MAT_RND);
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      if (sum_w[r][SUM_W-1:MAT_SH] > (SUM_W - MAT_SH)'(V_MAX)) begin
        xyz_r[r] <= XYZ_W'(V_MAX);
      end else begin
        xyz_r[r] <= XYZ_W'(sum_w[r][SUM_W-1:MAT_SH]);
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_cbrt
    s2lab_cbrt u_cbrt (
      .clk   (clk),
      .v_in  (xyz_r[r]),
      .f_out (f_w[r])
    );
  end

  always_ff @(posedge clk) begin
    l_r <= $signed(ACC_W'(f_w[1]) * ACC_W'(L_MUL) - ACC_W'(L_OFS));
    a_r <= $signed((ACC_W'(f_w[0]) - ACC_W'(f_w[1])) * ACC_W'(A_MUL));
    b_r <= $signed((ACC_W'(f_w[1]) - ACC_W'(f_w[2])) * ACC_W'(B_MUL));
  end

  always_comb begin
    if (l_r < 0) begin
      l_clip = '0;
    end else if (l_r > L_TOP) begin
      l_clip = L_TOP;
    end else begin
      l_clip = l_r;
    end
    l_rnd = (l_clip + RND_HALF) >>> SH;
  end

  always_ff @(posedge clk) begin
    out_r.lightness <= (l_rnd > L_LIM) ? 15'h7fff : 15'(l_rnd);
    out_r.a_star    <= round_sat(a_r);
    out_r.b_star    <= round_sat(b_r);
  end

  assign busy      = busy_r;
  assign out_valid = vld_r[PIPE_DEPTH-1];
  assign out_lab   = out_r;

endmodule

### rtl/core/s2lab_cbrt.sv
module s2lab_cbrt (
  input  logic                           clk,
  input  logic [s2lab_pkg::XYZ_W-1:0]    v_in,
  output logic [s2lab_pkg::F_W-1:0]      f_out
);
  import s2lab_pkg::*;

  logic [XYZ_W-1:0]  v_r     [CBRT_STEPS-1];
  logic [REM_W-1:0]  rem_r   [CBRT_STEPS-1];
  logic [SQ_W-1:0]   y2_r    [CBRT_STEPS-1];
  logic [F_W-1:0]    y_r     [CBRT_STEPS];
  logic              small_r [CBRT_STEPS];
  logic [LN_N_W-1:0] ln_n_r;
  logic [LN_P_W-1:0] ln_p_r;
  logic [F_W-1:0]    ln_d_r  [CBRT_STEPS-2];
  logic [F_W-1:0]    f_r;

  // One result bit per stage: the radicand v * 2^40 is consumed three bits at
  // a time, keeping the partial root, its square and the remainder.
  for (genvar k = 0; k < CBRT_STEPS; k++) begin : g_step
    localparam int G = CBRT_STEPS - 1 - k;
    logic [XYZ_W-1:0] v_i;
    logic             sm_i;
    logic [REM_W-1:0] rem_i;
    logic [F_W-1:0]   y_i;
    logic [SQ_W-1:0]  y2_i;
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] delta;
    logic             ge;

    if (k == 0) begin : g_head
      assign v_i   = v_in;
      assign sm_i  = (v_in <= XYZ_W'(F_THRESH));
      assign rem_i = '0;
      assign y_i   = '0;
      assign y2_i  = '0;
    end else begin : g_body
      assign v_i   = v_r[k-1];
      assign sm_i  = small_r[k-1];
      assign rem_i = rem_r[k-1];
      assign y_i   = y_r[k-1];
      assign y2_i  = y2_r[k-1];
    end

    assign rad    = {{(RAD_W - XYZ_W - RAD_SH){1'b0}}, v_i, {RAD_SH{1'b0}}};
    assign rem_sh = {rem_i[REM_W-4:0], rad[3*G+2 -: 3]};
    assign delta  = (REM_W'(y2_i) << 3) + (REM_W'(y2_i) << 2)
                  + (REM_W'(y_i) << 2) + (REM_W'(y_i) << 1) + REM_W'(1);
    assign ge     = (rem_sh >= delta);

    always_ff @(posedge clk) begin
      y_r[k]     <= {y_i[F_W-2:0], ge};
      small_r[k] <= sm_i;
    end

    if (k < CBRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        v_r[k]   <= v_i;
        rem_r[k] <= ge ? rem_sh - delta : rem_sh;
        y2_r[k]  <= ge ? (y2_i << 2) + (SQ_W'(y_i) << 2) + SQ_W'(1) : (y2_i << 2);
      end
    end
  end

  always_ff @(posedge clk) begin
    ln_n_r    <= LN_N_W'(v_in[LN_V_W-1:0]) * LN_N_W'(LIN_SLOPE) + LN_N_W'(LIN_RND);
    ln_p_r    <= LN_P_W'(ln_n_r) * LN_P_W'(RECIP_M);
    ln_d_r[0] <= F_W'(ln_p_r[LN_P_W-1:RECIP_SH]) + F_W'(F_OFFSET);
    for (int i = 1; i < CBRT_STEPS - 2; i++) begin
      ln_d_r[i] <= ln_d_r[i-1];
    end
    f_r <= small_r[CBRT_STEPS-1] ? ln_d_r[CBRT_STEPS-3] : y_r[CBRT_STEPS-1];
  end

  assign f_out = f_r;

endmodule

### rtl/core/s2lab_chk.sv
module s2lab_chk #(
  parameter int OUT_FRAC_BITS = s2lab_pkg::OUT_FRAC_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input s2lab_pkg::lab_out_t out_lab
);
  import s2lab_pkg::*;

  localparam int LAT = PIPE_DEPTH;
  localparam longint unsigned L_FULL = 64'd100 << OUT_FRAC_BITS;
  localparam logic [14:0] L_LIMIT = (L_FULL > 64'd32767) ? 15'h7fff : 15'(L_FULL);

  // Reset empties the pipeline and blocks new transactions.
  assert property (@(posedge clk) !rst_n |=> (busy && !out_valid))
    else $error("pipeline not idle after reset");

  // Every accepted transaction yields its result after the fixed latency.
  assert property (@(posedge clk) disable iff (!rst_n)
      (start && !busy) |-> ##LAT out_valid)
    else $error("result missing at the expected cycle");

  // No result appears without a transaction the fixed latency earlier.
  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching transaction");

  // Lightness never exceeds 100 at the output scale.
  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_lab.lightness <= L_LIMIT))
    else $error("lightness out of range");

endmodule

bind srgb_to_cielab_convert s2lab_chk #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_s2lab_chk (.*);
